// ===== hw/rtl/ofb_pkg.sv =====
`timescale 1ns / 1ps

package ofb_pkg;

  // field and datapath widths
  localparam int COORD_W = 12;
  localparam int DIM_W   = 13;
  localparam int PIX_W   = 16;
  localparam int DIST_W  = 13;
  localparam int DEN_W   = DIST_W + 1;
  localparam int PROD_W  = PIX_W + DIST_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int Q_W     = PIX_W;

  // configuration register indexes
  localparam logic [1:0] REG_HEIGHT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_SHIFT  = 2'd2;

  // result taken when the division is not used
  typedef struct packed {
    logic             use_alt;
    logic [PIX_W-1:0] alt;
  } side_t;

  // one division stage worth of state
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   quo;
    logic [DEN_W-1:0] den;
    side_t            side;
  } div_stage_t;

endpackage

// ===== hw/rtl/ofb_front.sv =====
`timescale 1ns / 1ps

module ofb_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [ofb_pkg::COORD_W-1:0] row,
  input  logic [ofb_pkg::COORD_W-1:0] col,
  input  logic [ofb_pkg::PIX_W-1:0]   first_pixel,
  input  logic [ofb_pkg::PIX_W-1:0]   second_pixel,
  input  logic [ofb_pkg::DIM_W-1:0]   overlap_height,
  input  logic [ofb_pkg::DIM_W-1:0]   overlap_width,
  input  logic                        shift_negative,
  output logic                        out_valid,
  output logic [ofb_pkg::NUM_W-1:0]   num,
  output logic [ofb_pkg::DEN_W-1:0]   den,
  output ofb_pkg::side_t              side
);

  logic [ofb_pkg::DIM_W-1:0]  row_x;
  logic [ofb_pkg::DIM_W-1:0]  col_x;
  logic [ofb_pkg::DIM_W-1:0]  h_left;
  logic [ofb_pkg::DIM_W-1:0]  w_left;
  logic [ofb_pkg::DIST_W-1:0] d1_next;
  logic [ofb_pkg::DIST_W-1:0] d2_next;

  logic                        a_valid;
  logic [ofb_pkg::DIST_W-1:0]  d1;
  logic [ofb_pkg::DIST_W-1:0]  d2;
  logic [ofb_pkg::PIX_W-1:0]   p1;
  logic [ofb_pkg::PIX_W-1:0]   p2;

  logic                        b_valid;
  logic [ofb_pkg::PROD_W-1:0]  prod1;
  logic [ofb_pkg::PROD_W-1:0]  prod2;
  logic [ofb_pkg::DEN_W-1:0]   b_den;
  ofb_pkg::side_t              b_side;
  ofb_pkg::side_t              side_next;

  // distances to the overlap edges; the remaining distance to the far edges is floored at zero
  always_comb begin
    row_x  = {1'b0, row};
    col_x  = {1'b0, col};
    h_left = (overlap_height > row_x) ? overlap_height - row_x : '0;
    w_left = (overlap_width > col_x) ? overlap_width - col_x : '0;
    if (shift_negative) begin
      d1_next = (row_x < w_left) ? row_x : w_left;
      d2_next = (h_left < col_x) ? h_left : col_x;
    end else begin
      d1_next = (row_x < col_x) ? row_x : col_x;
      d2_next = (h_left < w_left) ? h_left : w_left;
    end
  end

  // stage a: distances
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    d1 <= d1_next;
    d2 <= d2_next;
    p1 <= first_pixel;
    p2 <= second_pixel;
  end

  // background and zero-distance cases bypass the divider
  always_comb begin
    side_next.use_alt = 1'b1;
    side_next.alt     = p1;
    if (p1 == '0 || p2 == '0) begin
      side_next.alt = (p1 > p2) ? p1 : p2;
    end else if (d1 == '0 && d2 == '0) begin
      side_next.alt = p1;
    end else begin
      side_next.use_alt = 1'b0;
    end
  end

  // stage b: weighted products
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    prod1  <= ofb_pkg::PROD_W'(p1) * ofb_pkg::PROD_W'(d2);
    prod2  <= ofb_pkg::PROD_W'(p2) * ofb_pkg::PROD_W'(d1);
    b_den  <= {1'b0, d1} + {1'b0, d2};
    b_side <= side_next;
  end

  // stage c: numerator sum
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= b_valid;
    end
    num  <= {1'b0, prod1} + {1'b0, prod2};
    den  <= b_den;
    side <= b_side;
  end

endmodule

// ===== hw/rtl/ofb_div.sv =====
`timescale 1ns / 1ps

module ofb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [ofb_pkg::NUM_W-1:0] num,
  input  logic [ofb_pkg::DEN_W-1:0] den,
  input  ofb_pkg::side_t            in_side,
  output logic                      out_valid,
  output logic [ofb_pkg::Q_W-1:0]   quo,
  output ofb_pkg::side_t            out_side
);

  localparam int STAGES = ofb_pkg::Q_W;

  ofb_pkg::div_stage_t stg [0:STAGES];
  logic                vld [0:STAGES];

  // the quotient fits in Q_W bits, so the top numerator bits start below den
  always_comb begin
    stg[0].rem  = num[ofb_pkg::NUM_W-1 -: ofb_pkg::DEN_W];
    stg[0].low  = num[ofb_pkg::Q_W-1:0];
    stg[0].quo  = '0;
    stg[0].den  = den;
    stg[0].side = in_side;
    vld[0]      = in_valid;
  end

  // one restoring step per stage, one quotient bit each
  for (genvar k = 0; k < STAGES; k++) begin : g_step
    logic [ofb_pkg::DEN_W:0]   trial;
    logic                      fits;
    logic [ofb_pkg::DEN_W-1:0] rem_next;

    always_comb begin
      trial    = {stg[k].rem, stg[k].low[ofb_pkg::Q_W-1]};
      fits     = trial >= {1'b0, stg[k].den};
      rem_next = fits ? ofb_pkg::DEN_W'(trial - {1'b0, stg[k].den})
                      : trial[ofb_pkg::DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      stg[k+1].rem  <= rem_next;
      stg[k+1].low  <= {stg[k].low[ofb_pkg::Q_W-2:0], 1'b0};
      stg[k+1].quo  <= {stg[k].quo[ofb_pkg::Q_W-2:0], fits};
      stg[k+1].den  <= stg[k].den;
      stg[k+1].side <= stg[k].side;
    end
  end

  assign out_valid = vld[STAGES];
  assign quo       = stg[STAGES].quo;
  assign out_side  = stg[STAGES].side;

endmodule

// ===== hw/rtl/overlap_feather_blend_core.sv =====
`timescale 1ns / 1ps

// Feather blend of two 16-bit pixels by their distances to the overlap edges.
// One pixel pair is taken every clock: busy is always low, and each result
// appears on blended_pixel with done high for one cycle. Each pair passes
// through three front stages (distances, products, sum), a 16-stage divider
// that resolves one quotient bit per stage, and the output register. Results
// cannot be held off, so the receiver must take every one. Registers:
// overlap_height at 0x0, overlap_width at 0x4, shift_negative at 0x8;
// heights and widths whose low 13 bits exceed MAX_DIM are stored as
// MAX_DIM. Write the registers only while no pixel is in flight.
module overlap_feather_blend_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ofb_pkg::COORD_W-1:0] row,
  input  logic [ofb_pkg::COORD_W-1:0] col,
  input  logic [ofb_pkg::PIX_W-1:0]   first_pixel,
  input  logic [ofb_pkg::PIX_W-1:0]   second_pixel,
  output logic                        done,
  output logic [ofb_pkg::PIX_W-1:0]   blended_pixel,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [ofb_pkg::DIM_W-1:0] overlap_height;
  logic [ofb_pkg::DIM_W-1:0] overlap_width;
  logic                      shift_negative;
  logic [ofb_pkg::DIM_W-1:0] dim_next;
  logic                      cfg_write;
  logic [1:0]                reg_index;

  logic                      f_valid;
  logic [ofb_pkg::NUM_W-1:0] f_num;
  logic [ofb_pkg::DEN_W-1:0] f_den;
  ofb_pkg::side_t            f_side;

  logic                      q_valid;
  logic [ofb_pkg::Q_W-1:0]   q_quo;
  ofb_pkg::side_t            q_side;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // dimensions saturate at MAX_DIM
  always_comb begin
    dim_next = pwdata[ofb_pkg::DIM_W-1:0];
    if (32'(pwdata[ofb_pkg::DIM_W-1:0]) > MAX_DIM) begin
      dim_next = ofb_pkg::DIM_W'(MAX_DIM);
    end
  end

  // register write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_height <= '0;
      overlap_width  <= '0;
      shift_negative <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index)
        ofb_pkg::REG_HEIGHT: overlap_height <= dim_next;
        ofb_pkg::REG_WIDTH:  overlap_width  <= dim_next;
        ofb_pkg::REG_SHIFT:  shift_negative <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (reg_index)
      ofb_pkg::REG_HEIGHT: prdata = 32'(overlap_height);
      ofb_pkg::REG_WIDTH:  prdata = 32'(overlap_width);
      ofb_pkg::REG_SHIFT:  prdata = 32'(shift_negative);
      default:             prdata = '0;
    endcase
  end

  ofb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (start && !busy),
    .row            (row),
    .col            (col),
    .first_pixel    (first_pixel),
    .second_pixel   (second_pixel),
    .overlap_height (overlap_height),
    .overlap_width  (overlap_width),
    .shift_negative (shift_negative),
    .out_valid      (f_valid),
    .num            (f_num),
    .den            (f_den),
    .side           (f_side)
  );

  ofb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .num       (f_num),
    .den       (f_den),
    .in_side   (f_side),
    .out_valid (q_valid),
    .quo       (q_quo),
    .out_side  (q_side)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
    blended_pixel <= q_side.use_alt ? q_side.alt : q_quo;
  end

endmodule

// ===== test/overlap_feather_blend_core_test.sv =====
`timescale 1ns / 1ps

module overlap_feather_blend_core_test;

  localparam int MAX_DIM      = 4096;
  localparam int LATENCY      = 20;
  localparam int DRAIN_CYCLES = LATENCY + 5;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;

  // register index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [ofb_pkg::COORD_W-1:0]   row;
  logic [ofb_pkg::COORD_W-1:0]   col;
  logic [ofb_pkg::PIX_W-1:0]     first_pixel;
  logic [ofb_pkg::PIX_W-1:0]     second_pixel;
  logic                          done;
  logic [ofb_pkg::PIX_W-1:0]     blended_pixel;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [3:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  // shadow copy of the configuration
  logic [ofb_pkg::DIM_W-1:0]     cfg_height;
  logic [ofb_pkg::DIM_W-1:0]     cfg_width;
  logic                          cfg_shift_neg;

  logic [ofb_pkg::PIX_W-1:0]     expected_pixels[$];
  logic [ofb_pkg::PIX_W-1:0]     oldest_pixel;
  int                            error_count = 0;
  int                            cycle_count = 0;
  bit                            no_gaps = 1'b0;

  overlap_feather_blend_core #(
    .MAX_DIM(MAX_DIM)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .row(row),
    .col(col),
    .first_pixel(first_pixel),
    .second_pixel(second_pixel),
    .done(done),
    .blended_pixel(blended_pixel),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result check against the oldest expected pixel
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $error("blended_pixel: no result expected, actual %0h", blended_pixel);
        error_count++;
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        if (blended_pixel !== oldest_pixel) begin
          $error("blended_pixel: expected %0h, actual %0h", oldest_pixel, blended_pixel);
          error_count++;
        end
      end
    end
  end

  // distance-weighted blend of one pixel pair under the shadow configuration
  function automatic logic [ofb_pkg::PIX_W-1:0] feather_blend(
    input logic [ofb_pkg::COORD_W-1:0] r,
    input logic [ofb_pkg::COORD_W-1:0] c,
    input logic [ofb_pkg::PIX_W-1:0]   p1,
    input logic [ofb_pkg::PIX_W-1:0]   p2
  );
    logic [ofb_pkg::DIM_W-1:0]  rows_left;
    logic [ofb_pkg::DIM_W-1:0]  cols_left;
    logic [ofb_pkg::DIM_W-1:0]  d1;
    logic [ofb_pkg::DIM_W-1:0]  d2;
    logic [ofb_pkg::NUM_W-1:0]  num;
    logic [ofb_pkg::DEN_W-1:0]  den;
    logic [ofb_pkg::NUM_W-1:0]  quo;
    rows_left = (cfg_height > r) ? cfg_height - r : '0;
    cols_left = (cfg_width > c) ? cfg_width - c : '0;
    if (cfg_shift_neg) begin
      d1 = (r < cols_left) ? ofb_pkg::DIM_W'(r) : cols_left;
      d2 = (rows_left < c) ? rows_left : ofb_pkg::DIM_W'(c);
    end else begin
      d1 = (r < c) ? ofb_pkg::DIM_W'(r) : ofb_pkg::DIM_W'(c);
      d2 = (rows_left < cols_left) ? rows_left : cols_left;
    end
    // background pixel wins over everything else
    if (p1 == '0 || p2 == '0)
      return (p1 > p2) ? p1 : p2;
    if (d1 == '0 && d2 == '0)
      return p1;
    num = ofb_pkg::NUM_W'(p1) * ofb_pkg::NUM_W'(d2)
        + ofb_pkg::NUM_W'(p2) * ofb_pkg::NUM_W'(d1);
    den = ofb_pkg::DEN_W'(d1) + ofb_pkg::DEN_W'(d2);
    quo = num / ofb_pkg::NUM_W'(den);
    return quo[ofb_pkg::PIX_W-1:0];
  endfunction

  // gap between transfers: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // apb write, after which the bus idles before the task returns
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    logic [ofb_pkg::DIM_W-1:0] dim;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    dim = value[ofb_pkg::DIM_W-1:0];
    if (dim > MAX_DIM)
      dim = ofb_pkg::DIM_W'(MAX_DIM);
    case (idx)
      ofb_pkg::REG_HEIGHT: cfg_height = dim;
      ofb_pkg::REG_WIDTH:  cfg_width = dim;
      ofb_pkg::REG_SHIFT:  cfg_shift_neg = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_overlap(input logic [31:0] h, input logic [31:0] w, input logic neg);
    write_register(ofb_pkg::REG_HEIGHT, h);
    write_register(ofb_pkg::REG_WIDTH, w);
    write_register(ofb_pkg::REG_SHIFT, {31'd0, neg});
  endtask

  // one pixel pair transfer; start stays high when no gap follows
  task automatic send_pixel(
    input logic [ofb_pkg::COORD_W-1:0] r,
    input logic [ofb_pkg::COORD_W-1:0] c,
    input logic [ofb_pkg::PIX_W-1:0]   p1,
    input logic [ofb_pkg::PIX_W-1:0]   p2
  );
    int gap;
    start        <= 1'b1;
    row          <= r;
    col          <= c;
    first_pixel  <= p1;
    second_pixel <= p2;
    do @(posedge clk); while (busy);
    expected_pixels = {expected_pixels, feather_blend(r, c, p1, p2)};
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // lower start and wait for every result to come out
  task automatic drain();
    if (start)
      start <= 1'b0;
    while (expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // reset values: zero overlap, positive shift
  task automatic test_reset_defaults();
    send_pixel(12'd0, 12'd0, 16'd100, 16'd200);
    send_pixel(12'd5, 12'd7, 16'd300, 16'd40);
    drain();
  endtask

  // oversized dimensions saturate, unused index is ignored
  task automatic test_register_writes();
    write_register(ofb_pkg::REG_HEIGHT, 32'h0000_1FFF);
    write_register(ofb_pkg::REG_WIDTH, 32'hFFFF_FFFF);
    write_register(ofb_pkg::REG_SHIFT, 32'hFFFF_FFFE);
    write_register(REG_UNUSED, 32'h0000_0005);
    send_pixel(12'd4095, 12'd1, 16'd1000, 16'd3000);
    send_pixel(12'd2048, 12'd2048, 16'hFFFF, 16'd1);
    drain();
    write_register(ofb_pkg::REG_SHIFT, 32'h0000_0001);
    send_pixel(12'd100, 12'd4095, 16'd7, 16'hFFFE);
    drain();
  endtask

  // background pixels pass the larger value through
  task automatic test_background_pixels();
    set_overlap(32'd16, 32'd16, 1'b0);
    send_pixel(12'd3, 12'd4, 16'd0, 16'd1234);
    send_pixel(12'd3, 12'd4, 16'hFFFF, 16'd0);
    send_pixel(12'd0, 12'd0, 16'd0, 16'd0);
    drain();
  endtask

  // coordinate and pixel extremes under both shift directions
  task automatic test_field_extremes();
    set_overlap(32'd4096, 32'd4096, 1'b0);
    send_pixel(12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF);
    send_pixel(12'd4095, 12'd0, 16'd1, 16'hFFFF);
    send_pixel(12'd0, 12'd4095, 16'hFFFF, 16'd1);
    drain();
    write_register(ofb_pkg::REG_SHIFT, 32'd1);
    send_pixel(12'd4095, 12'd4095, 16'h8000, 16'h7FFF);
    send_pixel(12'd2047, 12'd1, 16'hAAAA, 16'h5555);
    drain();
  endtask

  // both distances zero and positions past the overlap edge
  task automatic test_overlap_edges();
    set_overlap(32'd10, 32'd20, 1'b0);
    send_pixel(12'd10, 12'd20, 16'd555, 16'd999);
    send_pixel(12'd12, 12'd25, 16'd321, 16'd123);
    send_pixel(12'd4, 12'd30, 16'd600, 16'd60);
    drain();
    write_register(ofb_pkg::REG_SHIFT, 32'd1);
    send_pixel(12'd0, 12'd0, 16'd777, 16'd888);
    send_pixel(12'd11, 12'd3, 16'd50, 16'd5000);
    send_pixel(12'd5, 12'd40, 16'd65000, 16'd2);
    drain();
  endtask

  function automatic logic [31:0] pick_dim();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd4096;
      3: return 32'd4095;
      4: return $urandom_range(4097, 8191) | ($urandom & 32'hFFFF_E000);
      5: return $urandom_range(2, 4096);
      default: return $urandom_range(2, 300);
    endcase
  endfunction

  // coordinate mostly inside the overlap, sometimes anywhere or on an edge
  function automatic logic [ofb_pkg::COORD_W-1:0] pick_coord(
    input logic [ofb_pkg::DIM_W-1:0] dim
  );
    int lim;
    int r;
    lim = (dim > 4095) ? 4095 : int'(dim);
    r = $urandom_range(0, 9);
    if (r < 7)
      return ofb_pkg::COORD_W'($urandom_range(0, lim));
    else if (r == 7)
      return ofb_pkg::COORD_W'($urandom);
    else if (r == 8)
      return ofb_pkg::COORD_W'(lim);
    return ofb_pkg::COORD_W'($urandom_range(0, 1) ? 0 : ((lim + 1 > 4095) ? 4095 : lim + 1));
  endfunction

  function automatic logic [ofb_pkg::PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 19);
    if (r < 17)
      return ofb_pkg::PIX_W'($urandom_range(1, 65535));
    else if (r == 17)
      return '0;
    return $urandom_range(0, 1) ? 16'hFFFF : 16'd1;
  endfunction

  // random overlap settings, each with a stream of pixel pairs
  task automatic test_random_streams();
    for (int ph = 0; ph < PHASES; ph++) begin
      set_overlap(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_pixel(pick_coord(cfg_height), pick_coord(cfg_width), pick_pixel(), pick_pixel());
      drain();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    row          <= '0;
    col          <= '0;
    first_pixel  <= '0;
    second_pixel <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    cfg_height    = '0;
    cfg_width     = '0;
    cfg_shift_neg = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_register_writes();
    test_background_pixels();
    test_field_extremes();
    test_overlap_edges();
    test_random_streams();

    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ofb_pkg.sv
hw/rtl/ofb_front.sv
hw/rtl/ofb_div.sv
hw/rtl/overlap_feather_blend_core.sv
test/overlap_feather_blend_core_test.sv
